// ===== rtl/mstt_pkg.sv =====
// Package for the MIDI stream to SMF track encoder.
// Holds shared constants and the status data-count function; no dependencies.
`default_nettype none
package mstt_pkg;
    localparam int unsigned SYSEX_DEPTH_DEF = 32;
    localparam logic [15:0] DIVISOR_RESET = 16'd15625;
    localparam logic [7:0] ST_SYSEX = 8'hF0;
    localparam logic [7:0] ST_EOX = 8'hF7;
    localparam logic [20:0] DELTA_MAX = 21'h1FFFFF;
    localparam logic REG_ENABLED = 1'b0;
    localparam logic REG_DIVISOR = 1'b1;

    function automatic logic [1:0] data_count(input logic [7:0] st);
        logic [1:0] c;
        c = 2'd0;
        unique case (st[7:4])
            4'h8, 4'h9, 4'hA, 4'hB, 4'hE: c = 2'd2;
            4'hC, 4'hD: c = 2'd1;
            4'hF: begin
                if (st == 8'hF1 || st == 8'hF3) c = 2'd1;
                else if (st == 8'hF2) c = 2'd2;
            end
            default: c = 2'd0;
        endcase
        return c;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/midi_stream_to_smf_track_core.sv =====
// MIDI byte stream to SMF track encoder: top level.
// Channels: s_axis request = {timestamp, midi_byte}, m_axis request = track byte with
// tlast marking the last byte of an event. Config: write port, index 0 enable,
// index 1 tick divisor. Uses mstt_pkg.
// Flow: a byte that completes no event leaves the input ready for the next byte.
// After a byte that completes an event, the first track byte passes through the
// serial delta division (S_DIV, one quotient bit per cycle), the delta set-up
// (S_WAIT) and the load of the output register (S_EMIT). Then one byte per cycle
// follows while the receiver takes them, with a priming read before the first data
// byte; data bytes are replayed from the event memory (one synchronous read port).
// The input is not accepted while an event is being emitted, so a stalled
// receiver holds the block; the output register keeps its byte until taken.
// Reset clears the parser, disables the block and restores the divisor.
// No clearing pass is needed; the memory is never read before written.
`default_nettype none
module midi_stream_to_smf_track_core #(
    parameter int unsigned SYSEX_DEPTH = mstt_pkg::SYSEX_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // midi_byte[7:0], timestamp[39:8]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // track_byte[7:0]
    output logic             m_axis_tlast
);
    import mstt_pkg::*;
    localparam int HW = $clog2(SYSEX_DEPTH + 1);
    localparam int AW = $clog2(SYSEX_DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0, S_DIV = 3'd1, S_EMIT = 3'd2, S_WAIT = 3'd3;
    localparam logic [2:0] K_D2 = 3'd0, K_D1 = 3'd1, K_D0 = 3'd2, K_ST = 3'd3,
                           K_L1 = 3'd4, K_L0 = 3'd5, K_DATA = 3'd6;

    logic [7:0] r_mem [SYSEX_DEPTH];
    logic [7:0] r_rdata;
    logic [2:0] r_state;
    logic [2:0] r_kind;
    logic r_en;
    logic [15:0] r_div;
    logic [7:0] r_rs;
    logic [1:0] r_exp;
    logic [HW-1:0] r_held;
    logic [HW-1:0] r_idx;
    logic [31:0] r_evt, r_prev;
    logic r_seen;
    logic [31:0] r_q;
    logic [15:0] r_rem;
    logic [5:0] r_cnt;
    logic [20:0] r_delta;
    logic r_ovalid;
    logic [7:0] r_obyte;
    logic r_olast;

    logic [7:0] in_b;
    logic [31:0] in_t;
    logic acc, fire, emit_go, out_free;
    logic prime, cfg_open, out_load;
    logic [15:0] dv;
    logic [16:0] trial;
    logic [7:0] n_byte;
    logic n_last;
    logic [2:0] n_kind;

    assign in_b = s_axis_tdata[7:0];
    assign in_t = s_axis_tdata[39:8];
    assign s_axis_tready = (r_state == S_IDLE);
    assign acc = s_axis_tvalid && s_axis_tready;
    assign dv = (r_div == 16'd0) ? 16'd1 : r_div;
    assign trial = {r_rem, r_q[31]} - {1'b0, dv};
    assign out_free = !r_ovalid || m_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = r_obyte;
    assign m_axis_tlast = r_olast;
    assign cfg_open = i_cfg_we && (i_cfg_index == REG_ENABLED) && i_cfg_wdata[0] && !r_en;

    // Decide whether the accepted byte stores and whether it completes an event.
    logic st_we;
    logic [AW-1:0] st_addr;
    always_comb begin
        st_we = 1'b0;
        fire = 1'b0;
        st_addr = r_held[AW-1:0];
        if (acc && r_en) begin
            if (r_rs == ST_SYSEX) begin
                if (r_held < HW'(SYSEX_DEPTH)) begin
                    st_we = 1'b1;
                    fire = (in_b == ST_EOX);
                end
            end else if (in_b[7]) begin
                fire = (in_b != ST_SYSEX) && (data_count(in_b) == 2'd0);
            end else if (r_held < HW'(r_exp)) begin
                st_we = 1'b1;
                fire = (r_held + HW'(1)) >= HW'(r_exp);
            end
        end
    end

    // Next byte of the event: varint delta, status, sysex length, data.
    always_comb begin
        n_byte = 8'h00;
        n_last = 1'b0;
        n_kind = r_kind;
        unique case (r_kind)
            K_D2: begin n_byte = {1'b1, r_delta[20:14]}; n_kind = K_D1; end
            K_D1: begin n_byte = {1'b1, r_delta[13:7]}; n_kind = K_D0; end
            K_D0: begin n_byte = {1'b0, r_delta[6:0]}; n_kind = K_ST; end
            K_ST: begin
                n_byte = r_rs;
                if (r_rs == ST_SYSEX)
                    n_kind = (r_held > HW'(127)) ? K_L1 : K_L0;
                else begin
                    n_kind = K_DATA;
                    n_last = (r_held == '0);
                end
            end
            K_L1: begin n_byte = 8'h80 | 8'(r_held >> 7); n_kind = K_L0; end
            K_L0: begin
                n_byte = {1'b0, 7'(r_held)};
                n_kind = K_DATA;
                n_last = (r_held == '0);
            end
            K_DATA: begin
                n_byte = r_rdata;
                n_last = (r_idx == r_held);
            end
            default: n_kind = K_D0;
        endcase
    end

    // Data bytes read one ahead; index points past the byte being read.
    assign emit_go = (r_state == S_EMIT) && out_free;
    assign prime = (r_kind == K_DATA) && (r_idx == '0) && (r_held != '0);
    assign out_load = emit_go && !prime && !cfg_open;

    always_ff @(posedge i_clk) begin
        if (st_we) r_mem[st_addr] <= in_b;
        if (emit_go && r_kind == K_DATA && r_idx != r_held)
            r_rdata <= r_mem[r_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_en <= 1'b0;
            r_div <= DIVISOR_RESET;
            r_rs <= '0;
            r_exp <= '0;
            r_held <= '0;
            r_seen <= 1'b0;
            r_evt <= '0;
            r_prev <= '0;
            r_ovalid <= 1'b0;
            r_kind <= K_D0;
            r_idx <= '0;
            r_cnt <= '0;
        end else begin
            if (out_load) r_ovalid <= 1'b1;
            else if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            if (i_cfg_we && i_cfg_index == REG_ENABLED) r_en <= i_cfg_wdata[0];
            if (i_cfg_we && i_cfg_index == REG_DIVISOR) r_div <= i_cfg_wdata;
            if (cfg_open) begin
                r_rs <= '0; r_exp <= '0; r_held <= '0; r_seen <= 1'b0;
            end else begin
                unique case (r_state)
                    S_IDLE: if (acc && r_en) begin
                        if (r_rs == ST_SYSEX) begin
                            if (st_we) r_held <= r_held + HW'(1);
                        end else if (in_b[7]) begin
                            r_rs <= in_b;
                            r_evt <= in_t;
                            r_held <= '0;
                            r_exp <= (in_b == ST_SYSEX) ? 2'd0 : data_count(in_b);
                        end else if (st_we) begin
                            if (r_held == '0) r_evt <= in_t;
                            r_held <= r_held + HW'(1);
                        end
                        if (fire) begin
                            r_state <= S_DIV;
                            r_cnt <= '0;
                            r_rem <= '0;
                            r_q <= ((r_held == '0 && !in_b[7] && r_rs != ST_SYSEX) || in_b[7]
                                    && r_rs != ST_SYSEX ? in_t : r_evt) - r_prev;
                            r_prev <= (r_held == '0 && !in_b[7] && r_rs != ST_SYSEX) ||
                                      (in_b[7] && r_rs != ST_SYSEX) ? in_t : r_evt;
                        end
                    end
                    S_DIV: begin
                        if (!trial[16]) begin
                            r_rem <= trial[15:0];
                            r_q <= {r_q[30:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[14:0], r_q[31]};
                            r_q <= {r_q[30:0], 1'b0};
                        end
                        r_cnt <= r_cnt + 6'd1;
                        if (r_cnt == 6'd31) r_state <= S_WAIT;
                    end
                    S_WAIT: begin
                        if (!r_seen) r_delta <= '0;
                        else if (r_q > 32'(DELTA_MAX)) r_delta <= DELTA_MAX;
                        else r_delta <= r_q[20:0];
                        r_seen <= 1'b1;
                        r_kind <= (r_seen && r_q > 32'h3FFF) ? K_D2 :
                                  (r_seen && r_q > 32'h7F) ? K_D1 : K_D0;
                        r_idx <= '0;
                        r_state <= S_EMIT;
                    end
                    S_EMIT: if (out_free) begin
                        if (prime) begin
                            r_idx <= HW'(1);
                        end else begin
                            r_obyte <= n_byte;
                            r_olast <= n_last;
                            r_kind <= n_kind;
                            if (r_kind == K_DATA) r_idx <= r_idx + HW'(1);
                            if (n_last) begin
                                r_state <= S_IDLE;
                                r_held <= '0;
                                if (r_rs == ST_SYSEX) begin
                                    r_rs <= '0; r_exp <= '0;
                                end
                            end
                        end
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/mstt_checker.sv =====
// Port-level checker for the SMF track encoder, bound to the top level.
// Uses only the top-level ports; no package dependency.
`default_nettype none
module mstt_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [7:0]  m_axis_tdata,
    input wire logic        m_axis_tlast
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output request changed while stalled");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input open in the middle of an event");
    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !$isunknown({m_axis_tdata, m_axis_tlast}))
        else $error("output request carries unknown bits");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");
endmodule
bind midi_stream_to_smf_track_core mstt_checker u_chk (.*);
`default_nettype wire
